### src/block_surface_lock_layout_macros.svh
// Assertion macros for the surface lock layout block.
// Used by the checker; needs clk and rst in the scope of each use.
`ifndef BLOCK_SURFACE_LOCK_LAYOUT_MACROS_SVH
`define BLOCK_SURFACE_LOCK_LAYOUT_MACROS_SVH

// checked outside reset
`define BSL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// checked during reset as well
`define BSL_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: reset assertion failed");

`endif

### src/bsl_pkg.sv
// Shared types and codes for the surface lock layout block.
// No dependencies.
package bsl_pkg;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_FORMAT   = 3'd1;
  localparam logic [2:0] STATUS_EXTENT   = 3'd2;
  localparam logic [2:0] STATUS_OVERFLOW = 3'd3;
  localparam logic [2:0] STATUS_PITCH    = 3'd4;
  localparam logic [2:0] STATUS_ALIGN    = 3'd5;

  localparam logic [1:0] FMT_DXT1  = 2'd0;
  localparam logic [1:0] FMT_DXT3  = 2'd1;
  localparam logic [1:0] FMT_DXT5  = 2'd2;
  localparam logic [1:0] FMT_OTHER = 2'd3;

  localparam logic [4:0] BPB_SMALL = 5'd8;
  localparam logic [4:0] BPB_LARGE = 5'd16;

  typedef struct packed {
    logic [1:0]  format_kind;
    logic [31:0] surf_width;
    logic [31:0] surf_height;
    logic signed [31:0] row_pitch;
    logic        has_rect;
    logic signed [31:0] rect_left;
    logic signed [31:0] rect_top;
    logic signed [31:0] rect_right;
    logic signed [31:0] rect_bottom;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  bytes_per_block;
    logic [31:0] full_row_size;
    logic [29:0] full_row_count;
    logic [28:0] first_block_col;
    logic [28:0] first_block_row;
    logic [31:0] rect_row_size;
    logic [29:0] rect_row_count;
    logic [61:0] packed_size;
    logic [61:0] source_span;
    logic        whole_surface;
  } rsp_t;

  // result of the front checks; extents valid only when status is OK
  typedef struct packed {
    logic [2:0]  status;
    logic        wide_block;
    logic [30:0] w;
    logic [30:0] h;
    logic [30:0] pitch;
    logic [30:0] l;
    logic [30:0] t;
    logic [30:0] r;
    logic [30:0] b;
    logic        whole;
  } check_t;

endpackage

### src/bsl_ifs.sv
// Request and response channel interfaces, valid/ready handshake.
// Depends on bsl_pkg.
interface bsl_req_if;
  logic           valid;
  logic           ready;
  bsl_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsl_rsp_if;
  logic           valid;
  logic           ready;
  bsl_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/bsl_check.sv
// Front validation of one lock request: format, extent, overflow, pitch sign
// and zero, rectangle bounds and alignment. Depends on bsl_pkg.
module bsl_check (
  input  bsl_pkg::req_t   req,
  output bsl_pkg::check_t chk
);

  logic [31:0] l, t, r, b;
  logic        fmt_bad, zero_ext, big_ext, pitch_bad, outside, misalign;
  logic [2:0]  status;

  always_comb begin
    if (req.has_rect) begin
      l = req.rect_left;
      t = req.rect_top;
      r = req.rect_right;
      b = req.rect_bottom;
    end else begin
      l = '0;
      t = '0;
      r = req.surf_width;
      b = req.surf_height;
    end
  end

  assign fmt_bad   = (req.format_kind == bsl_pkg::FMT_OTHER);
  assign zero_ext  = (req.surf_width == '0) || (req.surf_height == '0);
  assign big_ext   = req.surf_width[31] || req.surf_height[31];
  assign pitch_bad = req.row_pitch[31] || (req.row_pitch == '0);

  assign outside = l[31] || t[31] ||
                   ($signed(r) <= $signed(l)) || ($signed(b) <= $signed(t)) ||
                   r[31] || (r > req.surf_width) ||
                   b[31] || (b > req.surf_height);

  assign misalign = (l[1:0] != 2'b00) || (t[1:0] != 2'b00) ||
                    ((r[1:0] != 2'b00) && (r != req.surf_width)) ||
                    ((b[1:0] != 2'b00) && (b != req.surf_height));

  always_comb begin
    if (fmt_bad)        status = bsl_pkg::STATUS_FORMAT;
    else if (zero_ext)  status = bsl_pkg::STATUS_EXTENT;
    else if (big_ext)   status = bsl_pkg::STATUS_OVERFLOW;
    else if (pitch_bad) status = bsl_pkg::STATUS_PITCH;
    else if (outside)   status = bsl_pkg::STATUS_EXTENT;
    else if (misalign)  status = bsl_pkg::STATUS_ALIGN;
    else                status = bsl_pkg::STATUS_OK;
  end

  assign chk.status     = status;
  assign chk.wide_block = (req.format_kind != bsl_pkg::FMT_DXT1);
  assign chk.w          = req.surf_width[30:0];
  assign chk.h          = req.surf_height[30:0];
  assign chk.pitch      = req.row_pitch[30:0];
  assign chk.l          = l[30:0];
  assign chk.t          = t[30:0];
  assign chk.r          = r[30:0];
  assign chk.b          = b[30:0];
  assign chk.whole      = (l == '0) && (t == '0) &&
                          (r == req.surf_width) && (b == req.surf_height);

endmodule

### src/block_surface_lock_layout.sv
// Lock layout calculator for 4x4 block-compressed surfaces: one request in,
// one status plus row layout out. Depends on bsl_pkg, bsl_ifs, bsl_check.
//
// Takes one lock request per clock unless back-pressure holds the pipeline
// full, and returns its result through four register stages: request checks,
// block geometry and row-size overflow, a 32x30 and a 31x30 multiplier with
// the narrow-pitch check, and the final source-span add in the output
// register. Back-pressure on the response stalls only as many stages as are
// full; rejected requests carry their status with all layout fields zero.
module block_surface_lock_layout (
  input  logic         clk,
  input  logic         rst,
  bsl_req_if.sink      req,
  bsl_rsp_if.source    rsp
);

  typedef struct packed {
    logic [2:0]  status;
    logic        wide_block;
    logic [30:0] pitch;
    logic [31:0] frb;
    logic [29:0] full_rows;
    logic [28:0] col0;
    logic [28:0] row0;
    logic [31:0] row_bytes;
    logic [29:0] rows;
    logic        whole;
  } geom_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        wide_block;
    logic [31:0] frb;
    logic [29:0] full_rows;
    logic [28:0] col0;
    logic [28:0] row0;
    logic [31:0] row_bytes;
    logic [29:0] rows;
    logic [61:0] tight;
    logic [61:0] span_mul;
    logic        whole;
  } prod_t;

  bsl_pkg::check_t chk, s1;
  geom_t           s2, s2_next;
  prod_t           s3, s3_next;
  bsl_pkg::rsp_t   out_next;
  logic            v1, v2, v3, out_valid;
  logic            en1, en2, en3, en_out;

  bsl_check u_check (.req(req.data), .chk(chk));

  assign en_out    = !out_valid || rsp.ready;
  assign en3       = !v3 || en_out;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req.ready = en1;
  assign rsp.valid = out_valid;

  // stage 2: block geometry
  logic [31:0] w_sum, h_sum, r_sum, b_sum;
  logic [29:0] blocks_wide, col1, row1, cols;
  logic [33:0] frb34, row34;
  logic        row_ovf;

  always_comb begin
    w_sum       = {1'b0, s1.w} + 32'd3;
    h_sum       = {1'b0, s1.h} + 32'd3;
    r_sum       = {1'b0, s1.r} + 32'd3;
    b_sum       = {1'b0, s1.b} + 32'd3;
    blocks_wide = w_sum[31:2];
    col1        = r_sum[31:2];
    row1        = b_sum[31:2];
    cols        = col1 - {1'b0, s1.l[30:2]};
    frb34       = s1.wide_block ? {blocks_wide, 4'b0} : {1'b0, blocks_wide, 3'b0};
    row34       = s1.wide_block ? {cols, 4'b0} : {1'b0, cols, 3'b0};
    row_ovf     = (frb34[33:32] != 2'b00) || (row34[33:32] != 2'b00);

    s2_next.status     = (s1.status == bsl_pkg::STATUS_OK && row_ovf) ?
                         bsl_pkg::STATUS_OVERFLOW : s1.status;
    s2_next.wide_block = s1.wide_block;
    s2_next.pitch      = s1.pitch;
    s2_next.frb        = frb34[31:0];
    s2_next.full_rows  = h_sum[31:2];
    s2_next.col0       = s1.l[30:2];
    s2_next.row0       = s1.t[30:2];
    s2_next.row_bytes  = row34[31:0];
    s2_next.rows       = row1 - {1'b0, s1.t[30:2]};
    s2_next.whole      = s1.whole;
  end

  // stage 3: products and pitch width check
  always_comb begin
    s3_next.status     = (s2.status == bsl_pkg::STATUS_OK &&
                          {1'b0, s2.pitch} < s2.frb) ?
                         bsl_pkg::STATUS_PITCH : s2.status;
    s3_next.wide_block = s2.wide_block;
    s3_next.frb        = s2.frb;
    s3_next.full_rows  = s2.full_rows;
    s3_next.col0       = s2.col0;
    s3_next.row0       = s2.row0;
    s3_next.row_bytes  = s2.row_bytes;
    s3_next.rows       = s2.rows;
    s3_next.tight      = 62'(s2.row_bytes) * 62'(s2.rows);
    s3_next.span_mul   = 62'(s2.pitch) * 62'(s2.rows - 30'd1);
    s3_next.whole      = s2.whole;
  end

  // stage 4: span add, zero on reject
  always_comb begin
    out_next = '0;
    out_next.status = s3.status;
    if (s3.status == bsl_pkg::STATUS_OK) begin
      out_next.bytes_per_block = s3.wide_block ? bsl_pkg::BPB_LARGE : bsl_pkg::BPB_SMALL;
      out_next.full_row_size   = s3.frb;
      out_next.full_row_count  = s3.full_rows;
      out_next.first_block_col = s3.col0;
      out_next.first_block_row = s3.row0;
      out_next.rect_row_size   = s3.row_bytes;
      out_next.rect_row_count  = s3.rows;
      out_next.packed_size     = s3.tight;
      out_next.source_span     = s3.span_mul + 62'(s3.row_bytes);
      out_next.whole_surface   = s3.whole;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= req.valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en_out) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1)    s1       <= chk;
    if (en2)    s2       <= s2_next;
    if (en3)    s3       <= s3_next;
    if (en_out) rsp.data <= out_next;
  end

endmodule

### src/bsl_checker.sv
// Port-level checks for the surface lock layout block, bound to the top.
// Depends on bsl_pkg and block_surface_lock_layout_macros.svh.
`include "block_surface_lock_layout_macros.svh"

module bsl_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bsl_pkg::rsp_t rsp_data
);

  logic rejected;
  assign rejected = (rsp_data.status != bsl_pkg::STATUS_OK);

  `BSL_ASSERT_RST(a_idle_after_reset, rst |=> !rsp_valid)
  `BSL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
  `BSL_ASSERT(a_reject_zero, rsp_valid && rejected |-> (rsp_data.bytes_per_block == '0 && rsp_data.full_row_size == '0 && rsp_data.packed_size == '0 && rsp_data.source_span == '0 && !rsp_data.whole_surface))
  `BSL_ASSERT(a_whole_rows, rsp_valid && !rejected && rsp_data.whole_surface |-> (rsp_data.rect_row_size == rsp_data.full_row_size && rsp_data.rect_row_count == rsp_data.full_row_count))

endmodule

bind block_surface_lock_layout bsl_checker u_bsl_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
